>>> hdl/lsi_pkg.sv
// Package for the LED status indicator: pattern and action codes, register
// indexes, flash timing and modulator constants.
// No dependencies; imported by led_status_indicator_top.
`timescale 1ns / 1ps
`default_nettype none

package lsi_pkg;

	// Pattern shown, as reported on the result
	typedef enum logic [2:0] {
		PAT_LOWBATT  = 3'd0,
		PAT_BIND     = 3'd1,
		PAT_FAILSAFE = 3'd2,
		PAT_GESTURE  = 3'd3,
		PAT_BLINK    = 3'd4,
		PAT_STEADY   = 3'd5,
		PAT_DISABLED = 3'd6
	} pattern_t;

	// What the last stage does to the pins
	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_LIT   = 3'd1,
		ACT_UNLIT = 3'd2,
		ACT_MOD   = 3'd3,
		ACT_FLASH = 3'd4
	} act_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_BRIGHTNESS  = 2'd0,
		REG_LED_COUNT   = 2'd1,
		REG_INVERT_MASK = 2'd2,
		REG_LOOP_PERIOD = 2'd3
	} cfg_reg_t;

	// Register reset values
	localparam logic [3:0]  BRIGHT_RESET   = 4'd15;
	localparam logic [2:0]  COUNT_RESET    = 3'd4;
	localparam logic [3:0]  INVERT_RESET   = 4'd0;
	localparam logic [15:0] PERIOD_RESET   = 16'd250;
	localparam logic [3:0]  BRIGHT_FULL    = 4'd15;
	localparam int          LED_MAX_DEFAULT = 4;

	// Flash periods and on thresholds ((period * duty) >> 4)
	localparam logic [19:0] P_SLOW     = 20'd500000;
	localparam logic [19:0] P_FAST     = 20'd100000;
	localparam logic [19:0] T_LOWBATT  = 20'd250000;
	localparam logic [19:0] T_BIND     = 20'd75000;
	localparam logic [19:0] T_FAILSAFE = 20'd468750;
	localparam logic [19:0] T_GESTURE  = 20'd50000;

	// floor(2^32 / period) for the time remainders
	localparam logic [13:0] RCP_SLOW = 14'd8589;
	localparam logic [15:0] RCP_FAST = 16'd42949;

	// Gesture and blink timing
	localparam logic [31:0] MARK_SPAN_US = 32'd500000;
	localparam logic [31:0] BLINK_ON_US  = 32'd300000;
	localparam logic [31:0] ELAPSED_MAX  = 32'd65535;

	// Modulator, integrator in units of 1/(15*65536)
	localparam logic signed [23:0] INT_LIMIT     = 24'sd1966080;
	localparam logic signed [23:0] INT_THRESHOLD = 24'sd481689;
	localparam logic [21:0]        INC_MAX       = 22'h3FFFFF;

	// floor(2^36 / 250) and the divider's starting count
	localparam logic [36:0] RECIP_RESET = 37'd274877906;
	localparam logic [5:0]  DIV_FIRST   = 6'd36;

	// Lit test from an uncorrected remainder r in [0, 2p): true when
	// (r mod p) > t, with t below p.
	function automatic logic flash_lit(input logic [19:0] r, input logic [19:0] p,
			input logic [19:0] t);
		logic [20:0] tp;
		tp = {1'b0, t} + {1'b0, p};
		return ((r > t) && (r < p)) || ({1'b0, r} > tp);
	endfunction

endpackage

`default_nettype wire

>>> hdl/led_status_indicator_top.sv
// LED status indicator top level: tick pipeline, pattern control, flash
// timing and the first-order delta-sigma dimmer. Depends on lsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One tick per transaction, one transaction per clock while in_stall is low. An
// accepted tick passes through the pipeline stages into the output register. Pattern choice and
// the gesture and blink bookkeeping happen in the second stage; flash timing
// takes the time remainders by reciprocal multiplication; the dimmer step
// divides by loop_period_us through a stored reciprocal, computing both
// possible steps so that the integrator closes its loop in the last stage.
// A write to loop_period_us starts a bit-serial reciprocal update, during
// which in_stall is held high. After reset the reciprocal of
// the default period is ready at once. Results go out in tick order, exactly
// one per tick.
module led_status_indicator_top
	import lsi_pkg::*;
#(
	parameter int MAX_LEDS = LED_MAX_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// tick channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] now_us,
	input  wire logic        low_battery,
	input  wire logic        bind_mode,
	input  wire logic        failsafe_active,
	input  wire logic        start_gesture_flash,
	input  wire logic        blink_load,
	input  wire logic [3:0]  blink_count,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       led_levels,
	output logic [2:0]       pattern,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam logic [2:0] MaxLeds = 3'(MAX_LEDS);

	// configuration
	logic [3:0]  brightness_q;
	logic [2:0]  led_count_q;
	logic [3:0]  invert_q;
	logic [15:0] period_q;
	logic [15:0] p_eff;

	// reciprocal divider
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [15:0] rem_q;
	logic [36:0] recip_q;
	logic [16:0] div_sh;
	logic        div_ge;
	logic [16:0] div_rem;

	// control state
	logic        gesture_q;
	logic [3:0]  blinks_q;
	logic [31:0] mark_q;
	logic        mark_valid_q;
	logic [31:0] prev_q;

	// last-stage state
	logic [3:0]        pins_q;
	logic signed [21:0] integ_q;
	logic              last_lit_q;
	pattern_t          pattern_q;
	logic              out_valid_q;

	// handshake
	logic adv_out, adv1, adv2, adv3, adv4, adv5, adv6, adv7;
	logic load_out;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	// stage 1: accepted tick
	logic [31:0] now_s1;
	logic        lowbat_s1, bind_s1, fs_s1, gest_s1, load_s1;
	logic [3:0]  count_s1;

	// stage 2
	logic [31:0] now_s2;
	logic [13:0] qs_s2;
	logic [15:0] qf_s2;
	pattern_t    pat_s2;
	act_t        act_s2;
	logic [15:0] elapsed_s2;

	// stage 3
	logic [31:0] now_s3;
	logic [31:0] qps_s3, qpf_s3;
	pattern_t    pat_s3;
	act_t        act_s3;
	logic [19:0] xa_s3, xb_s3;

	// stage 4
	logic [19:0] rs_s4, rf_s4;
	pattern_t    pat_s4;
	act_t        act_s4;
	logic [38:0] plo_a_s4, plo_b_s4;
	logic [37:0] phi_a_s4, phi_b_s4;
	logic [1:0]  xa_lo_s4, xb_lo_s4;

	// stage 5
	pattern_t    pat_s5;
	act_t        act_s5;
	logic [36:0] q0a_s5, q0b_s5;
	logic [1:0]  xa_lo_s5, xb_lo_s5;

	// stage 6
	pattern_t    pat_s6;
	act_t        act_s6;
	logic [36:0] q0a_s6, q0b_s6;
	logic [17:0] ra_s6, rb_s6;

	// stage 7
	pattern_t    pat_s7;
	act_t        act_s7;
	logic [21:0] inca_s7, incb_s7;

	// control combinational
	logic        gest_n;
	logic [3:0]  blinks_n;
	logic [31:0] mark_n;
	logic        mark_valid_n;
	logic [31:0] prev_n;
	pattern_t    pat_c;
	act_t        act_c;
	logic [15:0] elapsed_c;
	logic [31:0] mark_base, mark_el, prev_el;

	// datapath combinational
	logic [45:0] prods_c;
	logic [47:0] prodf_c;
	logic [32:0] qps_c;
	logic [32:0] qpf_c;
	logic [31:0] rs_c, rf_c;
	logic        flash_c;
	act_t        act5_c;
	logic [56:0] suma_c, sumb_c;
	logic [33:0] mula_c, mulb_c;
	logic [37:0] inca_full, incb_full;

	// last stage combinational
	logic signed [23:0] acc_a, acc_b, acc;
	logic signed [23:0] acc_clamp;
	logic               mod_lit;
	logic               drive_en, drive_lit;
	logic [2:0]         fitted_n;
	logic [3:0]         fit;
	logic [3:0]         lvl;
	logic [3:0]         pins_n;

	// ---------------- handshake ----------------
	assign adv_out   = !out_valid_q || !out_stall;
	assign adv7      = !valid_s7 || adv_out;
	assign adv6      = !valid_s6 || adv7;
	assign adv5      = !valid_s5 || adv6;
	assign adv4      = !valid_s4 || adv5;
	assign adv3      = !valid_s3 || adv4;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign in_stall  = !adv1 || busy_q;
	assign load_out  = adv_out && valid_s7;
	assign out_valid = out_valid_q;
	assign led_levels = pins_q;
	assign pattern    = pattern_q;
	assign cfg_ready  = 1'b1;

	assign p_eff = (period_q == 16'd0) ? 16'd1 : period_q;

	// ---------------- reciprocal divider: floor(2^36 / p) ----------------
	always_comb begin
		div_sh  = {rem_q, (cnt_q == DIV_FIRST)};
		div_ge  = div_sh >= {1'b0, p_eff};
		div_rem = div_ge ? (div_sh - {1'b0, p_eff}) : div_sh;
	end

	// ---------------- pattern control (stage 1 -> 2) ----------------
	always_comb begin
		gest_n       = gesture_q | gest_s1;
		blinks_n     = load_s1 ? count_s1 : blinks_q;
		mark_n       = mark_q;
		mark_valid_n = mark_valid_q;
		prev_n       = prev_q;
		pat_c        = PAT_STEADY;
		act_c        = ACT_NONE;
		elapsed_c    = 16'd0;
		mark_base    = mark_valid_q ? mark_q : now_s1;
		mark_el      = now_s1 - mark_base;
		prev_el      = now_s1 - prev_q;
		if (led_count_q == 3'd0) begin
			pat_c = PAT_DISABLED;
		end else if (lowbat_s1) begin
			pat_c = PAT_LOWBATT;
			act_c = ACT_FLASH;
		end else if (bind_s1) begin
			pat_c = PAT_BIND;
			act_c = ACT_FLASH;
		end else if (fs_s1) begin
			pat_c = PAT_FAILSAFE;
			act_c = ACT_FLASH;
		end else if (gest_n) begin
			pat_c = PAT_GESTURE;
			act_c = ACT_FLASH;
			if (!mark_valid_q) begin
				mark_n       = now_s1;
				mark_valid_n = 1'b1;
			end
			if (mark_el > MARK_SPAN_US) begin
				gest_n       = 1'b0;
				mark_valid_n = 1'b0;
			end
		end else if (blinks_n != 4'd0) begin
			pat_c = PAT_BLINK;
			// new mark starts the blink unlit; measured from the old mark otherwise
			if (!mark_valid_q) begin
				mark_n       = now_s1;
				mark_valid_n = 1'b1;
				act_c        = ACT_UNLIT;
			end
			if (mark_el > MARK_SPAN_US) begin
				blinks_n     = blinks_n - 4'd1;
				mark_valid_n = 1'b0;
			end
			if (mark_el > BLINK_ON_US)
				act_c = ACT_LIT;
		end else begin
			pat_c = PAT_STEADY;
			if (brightness_q != BRIGHT_FULL) begin
				act_c     = ACT_MOD;
				prev_n    = now_s1;
				elapsed_c = (prev_el > ELAPSED_MAX) ? ELAPSED_MAX[15:0] : prev_el[15:0];
			end else begin
				act_c = ACT_LIT;
			end
		end
	end

	// ---------------- datapath ----------------
	always_comb begin
		// time remainders: estimate quotient, then r in [0, 2p)
		prods_c = 46'(now_s1) * 46'(RCP_SLOW);
		prodf_c = 48'(now_s1) * 48'(RCP_FAST);
		qps_c   = 33'(qs_s2) * 33'(P_SLOW);
		qpf_c   = 33'(qf_s2) * 33'(P_FAST);
		rs_c    = now_s3 - qps_s3;
		rf_c    = now_s3 - qpf_s3;

		// resolve flashes to lit or unlit
		case (pat_s4)
			PAT_LOWBATT:  flash_c = flash_lit(rs_s4, P_SLOW, T_LOWBATT);
			PAT_BIND:     flash_c = flash_lit(rf_s4, P_FAST, T_BIND);
			PAT_FAILSAFE: flash_c = flash_lit(rs_s4, P_SLOW, T_FAILSAFE);
			PAT_GESTURE:  flash_c = flash_lit(rf_s4, P_FAST, T_GESTURE);
			default:      flash_c = 1'b0;
		endcase
		if (act_s4 == ACT_FLASH)
			act5_c = flash_c ? ACT_LIT : ACT_UNLIT;
		else
			act5_c = act_s4;

		// step quotient estimate: (x * recip) >> 20, low by at most one
		suma_c = {phi_a_s4, 19'b0} + 57'(plo_a_s4);
		sumb_c = {phi_b_s4, 19'b0} + 57'(plo_b_s4);

		// low bits of x*2^16 - q0*p give the remainder exactly
		mula_c = 34'(q0a_s5[17:0]) * 34'(p_eff);
		mulb_c = 34'(q0b_s5[17:0]) * 34'(p_eff);

		inca_full = 38'(q0a_s6) + 38'(ra_s6 >= 18'(p_eff));
		incb_full = 38'(q0b_s6) + 38'(rb_s6 >= 18'(p_eff));
	end

	// ---------------- last stage: integrator and pin drive ----------------
	always_comb begin
		acc_a   = $signed({{2{integ_q[21]}}, integ_q}) + $signed({2'b00, inca_s7});
		acc_b   = $signed({{2{integ_q[21]}}, integ_q}) - $signed({2'b00, incb_s7});
		acc     = last_lit_q ? acc_b : acc_a;
		mod_lit = acc > INT_THRESHOLD;
		if (acc > INT_LIMIT)
			acc_clamp = INT_LIMIT;
		else if (acc < -INT_LIMIT)
			acc_clamp = -INT_LIMIT;
		else
			acc_clamp = acc;

		case (act_s7)
			ACT_LIT: begin
				drive_en  = 1'b1;
				drive_lit = 1'b1;
			end
			ACT_UNLIT: begin
				drive_en  = 1'b1;
				drive_lit = 1'b0;
			end
			ACT_MOD: begin
				drive_en  = 1'b1;
				drive_lit = mod_lit;
			end
			default: begin
				drive_en  = 1'b0;
				drive_lit = 1'b0;
			end
		endcase

		fitted_n = (led_count_q > MaxLeds) ? MaxLeds : led_count_q;
		for (int i = 0; i < 4; i++)
			fit[i] = 3'(i) < fitted_n;
		lvl    = drive_lit ? ~invert_q : invert_q;
		pins_n = drive_en ? ((pins_q & ~fit) | (lvl & fit)) : pins_q;
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHT_RESET;
			led_count_q  <= COUNT_RESET;
			invert_q     <= INVERT_RESET;
			period_q     <= PERIOD_RESET;
			busy_q       <= 1'b0;
			cnt_q        <= 6'd0;
			rem_q        <= 16'd0;
			recip_q      <= RECIP_RESET;
			gesture_q    <= 1'b0;
			blinks_q     <= 4'd0;
			mark_q       <= 32'd0;
			mark_valid_q <= 1'b0;
			prev_q       <= 32'd0;
			pins_q       <= 4'd0;
			integ_q      <= 22'sd0;
			last_lit_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			valid_s5     <= 1'b0;
			valid_s6     <= 1'b0;
			valid_s7     <= 1'b0;
		end else begin
			// reciprocal update, one quotient bit a cycle
			if (busy_q) begin
				rem_q   <= div_rem[15:0];
				recip_q <= {recip_q[35:0], div_ge};
				cnt_q   <= cnt_q - 6'd1;
				if (cnt_q == 6'd0)
					busy_q <= 1'b0;
			end

			// configuration transaction
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_BRIGHTNESS:  brightness_q <= cfg_data[3:0];
					REG_LED_COUNT:   led_count_q  <= cfg_data[2:0];
					REG_INVERT_MASK: invert_q     <= cfg_data[3:0];
					REG_LOOP_PERIOD: begin
						period_q <= cfg_data;
						busy_q   <= 1'b1;
						cnt_q    <= DIV_FIRST;
						rem_q    <= 16'd0;
					end
				endcase
			end

			// stage valid bits
			if (adv1)
				valid_s1 <= in_valid && !busy_q;
			if (adv2)
				valid_s2 <= valid_s1;
			if (adv3)
				valid_s3 <= valid_s2;
			if (adv4)
				valid_s4 <= valid_s3;
			if (adv5)
				valid_s5 <= valid_s4;
			if (adv6)
				valid_s6 <= valid_s5;
			if (adv7)
				valid_s7 <= valid_s6;
			if (adv_out)
				out_valid_q <= valid_s7;

			// pattern bookkeeping as a tick leaves stage 1
			if (adv2 && valid_s1) begin
				gesture_q    <= gest_n;
				blinks_q     <= blinks_n;
				mark_q       <= mark_n;
				mark_valid_q <= mark_valid_n;
				prev_q       <= prev_n;
			end

			// pins and modulator as a result is loaded
			if (load_out) begin
				pins_q <= pins_n;
				if (act_s7 == ACT_MOD) begin
					integ_q    <= acc_clamp[21:0];
					last_lit_q <= mod_lit;
				end
			end
		end
	end

	// ---------------- pipeline payload ----------------
	always_ff @(posedge clk) begin
		if (adv1) begin
			now_s1    <= now_us;
			lowbat_s1 <= low_battery;
			bind_s1   <= bind_mode;
			fs_s1     <= failsafe_active;
			gest_s1   <= start_gesture_flash;
			load_s1   <= blink_load;
			count_s1  <= blink_count;
		end
		if (adv2) begin
			now_s2     <= now_s1;
			qs_s2      <= prods_c[45:32];
			qf_s2      <= prodf_c[47:32];
			pat_s2     <= pat_c;
			act_s2     <= act_c;
			elapsed_s2 <= elapsed_c;
		end
		if (adv3) begin
			now_s3 <= now_s2;
			qps_s3 <= qps_c[31:0];
			qpf_s3 <= qpf_c[31:0];
			pat_s3 <= pat_s2;
			act_s3 <= act_s2;
			xa_s3  <= {16'd0, brightness_q} * {4'd0, elapsed_s2};
			xb_s3  <= {16'd0, BRIGHT_FULL - brightness_q} * {4'd0, elapsed_s2};
		end
		if (adv4) begin
			rs_s4    <= rs_c[19:0];
			rf_s4    <= rf_c[19:0];
			pat_s4   <= pat_s3;
			act_s4   <= act_s3;
			plo_a_s4 <= 39'(xa_s3) * 39'(recip_q[18:0]);
			plo_b_s4 <= 39'(xb_s3) * 39'(recip_q[18:0]);
			phi_a_s4 <= 38'(xa_s3) * 38'(recip_q[36:19]);
			phi_b_s4 <= 38'(xb_s3) * 38'(recip_q[36:19]);
			xa_lo_s4 <= xa_s3[1:0];
			xb_lo_s4 <= xb_s3[1:0];
		end
		if (adv5) begin
			pat_s5   <= pat_s4;
			act_s5   <= act5_c;
			q0a_s5   <= suma_c[56:20];
			q0b_s5   <= sumb_c[56:20];
			xa_lo_s5 <= xa_lo_s4;
			xb_lo_s5 <= xb_lo_s4;
		end
		if (adv6) begin
			pat_s6 <= pat_s5;
			act_s6 <= act_s5;
			q0a_s6 <= q0a_s5;
			q0b_s6 <= q0b_s5;
			ra_s6  <= {xa_lo_s5, 16'd0} - mula_c[17:0];
			rb_s6  <= {xb_lo_s5, 16'd0} - mulb_c[17:0];
		end
		if (adv7) begin
			pat_s7  <= pat_s6;
			act_s7  <= act_s6;
			// steps this large clamp the integrator either way
			inca_s7 <= (inca_full > 38'(INC_MAX)) ? INC_MAX : inca_full[21:0];
			incb_s7 <= (incb_full > 38'(INC_MAX)) ? INC_MAX : incb_full[21:0];
		end
		if (load_out)
			pattern_q <= pat_s7;
	end

	// ---------------- assertions ----------------
	// integrator never leaves its clamp range
	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		(integ_q <= INT_LIMIT) && (integ_q >= -INT_LIMIT))
		else $error("integrator out of range");

	// a result appears only from a full last stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s7))
		else $error("result without a tick behind it");

	// pins move only when a result is loaded
	a_pins_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(load_out) |-> $stable(pins_q))
		else $error("pins changed without a result");

	// ticks that do not drive leave the pins alone
	a_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (act_s7 == ACT_NONE)) |=> $stable(pins_q))
		else $error("pins changed on a non-driving tick");

endmodule

`default_nettype wire

>>> tb/sv/led_status_indicator_top_tb.sv
// Self-checking testbench for led_status_indicator_top: directed priority,
// timing and register corner tests, then randomized ticks over register settings.
// Depends on lsi_pkg and the led_status_indicator_top RTL.
`timescale 1ns / 1ps

module led_status_indicator_top_tb;
	import lsi_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASES       = 10;
	localparam int PHASE_TICKS  = 185;
	localparam int SHOW_MAX     = 10;
	localparam int LED_FIT_MAX  = 4;

	// flash timing and dimmer constants
	localparam logic [31:0] SLOW_US       = 32'd500000;
	localparam logic [31:0] FAST_US       = 32'd100000;
	localparam logic [31:0] DUTY_LOWBAT   = 32'd8;
	localparam logic [31:0] DUTY_BIND     = 32'd12;
	localparam logic [31:0] DUTY_FS       = 32'd15;
	localparam logic [31:0] DUTY_GESTURE  = 32'd8;
	localparam logic [31:0] MARK_LIMIT_US = 32'd500000;
	localparam logic [31:0] LIT_AFTER_US  = 32'd300000;
	localparam logic [31:0] SPAN_CAP      = 32'd65535;
	localparam longint      DIM_CLAMP     = 1966080;
	localparam longint      DIM_ON_LEVEL  = 481689;
	localparam longint      FULL_STEP     = 15;

	// flag bits for building ticks
	localparam logic [4:0] F_NONE     = 5'b00000;
	localparam logic [4:0] F_LOWBAT   = 5'b00001;
	localparam logic [4:0] F_BIND     = 5'b00010;
	localparam logic [4:0] F_FAILSAFE = 5'b00100;
	localparam logic [4:0] F_GESTURE  = 5'b01000;
	localparam logic [4:0] F_LOAD     = 5'b10000;

	typedef struct packed {
		logic [31:0] stamp;
		logic        lowbat;
		logic        binding;
		logic        failsafe;
		logic        gesture;
		logic        load;
		logic [3:0]  count;
	} tick_t;

	typedef struct packed {
		logic [3:0] levels;
		pattern_t   pat;
	} leds_t;

	logic        clk;
	logic        arst_n              = 1'b0;
	logic        in_valid            = 1'b0;
	logic        in_stall;
	logic [31:0] now_us              = '0;
	logic        low_battery         = 1'b0;
	logic        bind_mode           = 1'b0;
	logic        failsafe_active     = 1'b0;
	logic        start_gesture_flash = 1'b0;
	logic        blink_load          = 1'b0;
	logic [3:0]  blink_count         = '0;
	logic        out_valid;
	logic        out_stall           = 1'b0;
	logic [3:0]  led_levels;
	logic [2:0]  pattern;
	logic        cfg_valid           = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index           = '0;
	logic [15:0] cfg_data            = '0;

	led_status_indicator_top dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.now_us              (now_us),
		.low_battery         (low_battery),
		.bind_mode           (bind_mode),
		.failsafe_active     (failsafe_active),
		.start_gesture_flash (start_gesture_flash),
		.blink_load          (blink_load),
		.blink_count         (blink_count),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.led_levels          (led_levels),
		.pattern             (pattern),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	// register shadow
	logic [3:0]  cfg_bright = BRIGHT_RESET;
	logic [2:0]  cfg_count  = COUNT_RESET;
	logic [3:0]  cfg_inv    = INVERT_RESET;
	logic [15:0] cfg_period = PERIOD_RESET;

	// indicator state as the block should hold it
	logic [3:0]  pins     = '0;
	logic        gest_on  = 1'b0;
	logic [3:0]  blinks   = '0;
	logic [31:0] mark_us  = '0;
	logic        mark_set = 1'b0;
	logic [31:0] prev_us  = '0;
	longint      integ    = 0;
	logic        dim_lit  = 1'b0;

	leds_t       led_queue[$];
	int          errors          = 0;
	int          ticks_sent      = 0;
	int          results_checked = 0;
	int          reg_writes      = 0;
	int          cycles          = 0;
	int          pat_seen[7];
	logic        steady_flow     = 1'b0;
	logic [31:0] clock_us        = '0;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				led_queue.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// random backpressure on the result side
	always @(negedge clk) begin
		out_stall <= !steady_flow && ($urandom_range(0, 99) < 36);
	end

	// ---------------- prediction ----------------

	function automatic logic [3:0] fitted_leds();
		int n;
		n = (cfg_count > LED_FIT_MAX) ? LED_FIT_MAX : int'(cfg_count);
		return 4'((1 << n) - 1);
	endfunction

	task automatic drive_pins(input logic lit);
		logic [3:0] f;
		logic [3:0] lvl;
		f = fitted_leds();
		lvl = lit ? ~cfg_inv : cfg_inv;
		pins = (pins & ~f) | (lvl & f);
	endtask

	function automatic logic flash_on(input logic [31:0] stamp, input logic [31:0] per,
			input logic [31:0] duty);
		logic [31:0] on_mark;
		on_mark = (per * duty) >> 4;
		return (stamp % per) > on_mark;
	endfunction

	function automatic longint clamp_dim(input longint v);
		if (v > DIM_CLAMP)
			return DIM_CLAMP;
		if (v < -DIM_CLAMP)
			return -DIM_CLAMP;
		return v;
	endfunction

	// first-order delta-sigma step for a dimmed steady tick
	task automatic step_dimmer(input logic [31:0] stamp);
		logic [31:0] span;
		longint      acc;
		longint      diff;
		longint      mag;
		longint      per;
		span = stamp - prev_us;
		if (span > SPAN_CAP)
			span = SPAN_CAP;
		prev_us = stamp;
		per = (cfg_period == 16'd0) ? 64'sd1 : longint'({48'd0, cfg_period});
		acc = clamp_dim(integ);
		diff = longint'({60'd0, cfg_bright}) - (dim_lit ? FULL_STEP : 64'sd0);
		mag = (diff < 0 ? -diff : diff) * longint'({32'd0, span}) * 64'sd65536 / per;
		acc = acc + ((diff < 0) ? -mag : mag);
		dim_lit = (acc > DIM_ON_LEVEL);
		drive_pins(dim_lit);
		integ = clamp_dim(acc);
	endtask

	// expected LED levels and pattern for one accepted tick
	task automatic predict_leds(input tick_t t, output leds_t r);
		logic [31:0] span;
		if (t.gesture)
			gest_on = 1'b1;
		if (t.load)
			blinks = t.count;
		if (cfg_count == 3'd0) begin
			r.pat = PAT_DISABLED;
		end else if (t.lowbat) begin
			drive_pins(flash_on(t.stamp, SLOW_US, DUTY_LOWBAT));
			r.pat = PAT_LOWBATT;
		end else if (t.binding) begin
			drive_pins(flash_on(t.stamp, FAST_US, DUTY_BIND));
			r.pat = PAT_BIND;
		end else if (t.failsafe) begin
			drive_pins(flash_on(t.stamp, SLOW_US, DUTY_FS));
			r.pat = PAT_FAILSAFE;
		end else if (gest_on) begin
			if (!mark_set) begin
				mark_us = t.stamp;
				mark_set = 1'b1;
			end
			span = t.stamp - mark_us;
			if (span > MARK_LIMIT_US) begin
				gest_on = 1'b0;
				mark_set = 1'b0;
			end
			drive_pins(flash_on(t.stamp, FAST_US, DUTY_GESTURE));
			r.pat = PAT_GESTURE;
		end else if (blinks != 4'd0) begin
			// a fresh mark starts the blink dark; the count drops on the old mark
			if (!mark_set) begin
				mark_us = t.stamp;
				mark_set = 1'b1;
				drive_pins(1'b0);
			end
			span = t.stamp - mark_us;
			if (span > MARK_LIMIT_US) begin
				blinks = blinks - 4'd1;
				mark_set = 1'b0;
			end
			if (span > LIT_AFTER_US)
				drive_pins(1'b1);
			r.pat = PAT_BLINK;
		end else begin
			if (cfg_bright != BRIGHT_FULL)
				step_dimmer(t.stamp);
			else
				drive_pins(1'b1);
			r.pat = PAT_STEADY;
		end
		r.levels = pins;
	endtask

	// ---------------- checking ----------------

	always @(posedge clk) begin
		leds_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (led_queue.size() == 0) begin
				errors++;
				if (errors <= SHOW_MAX)
					$display("unexpected result: leds %h pattern %0d", led_levels, pattern);
			end else begin
				want = led_queue.pop_front();
				if (want.levels !== led_levels || want.pat !== pattern) begin
					errors++;
					if (errors <= SHOW_MAX)
						$display("mismatch on result %0d: expected leds %h pattern %0d, got leds %h pattern %0d",
							results_checked, want.levels, want.pat, led_levels, pattern);
				end
				results_checked++;
			end
		end
	end

	// ---------------- driving ----------------

	function automatic tick_t mk_tick(input logic [31:0] stamp, input logic [4:0] flags,
			input logic [3:0] count);
		tick_t t;
		t.stamp = stamp;
		t.lowbat = flags[0];
		t.binding = flags[1];
		t.failsafe = flags[2];
		t.gesture = flags[3];
		t.load = flags[4];
		t.count = count;
		return t;
	endfunction

	// one tick transaction, with random gaps ahead of it
	task automatic send_tick(input tick_t t);
		leds_t want;
		@(negedge clk);
		while (!steady_flow && $urandom_range(0, 99) < 36) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		now_us <= t.stamp;
		low_battery <= t.lowbat;
		bind_mode <= t.binding;
		failsafe_active <= t.failsafe;
		start_gesture_flash <= t.gesture;
		blink_load <= t.load;
		blink_count <= t.count;
		do
			@(posedge clk);
		while (in_stall);
		predict_leds(t, want);
		led_queue.push_back(want);
		ticks_sent++;
		pat_seen[want.pat]++;
	endtask

	// stop sending and let every outstanding result arrive
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (led_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_BRIGHTNESS:  cfg_bright = val[3:0];
			REG_LED_COUNT:   cfg_count = val[2:0];
			REG_INVERT_MASK: cfg_inv = val[3:0];
			REG_LOOP_PERIOD: cfg_period = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [3:0] bright, input logic [2:0] count,
			input logic [3:0] inv, input logic [15:0] per);
		wait_idle();
		write_reg(REG_BRIGHTNESS, {12'd0, bright});
		write_reg(REG_LED_COUNT, {13'd0, count});
		write_reg(REG_INVERT_MASK, {12'd0, inv});
		write_reg(REG_LOOP_PERIOD, per);
	endtask

	// ---------------- tests ----------------

	// flash thresholds at their exact edges, and priority with every flag set
	task automatic test_flash_thresholds();
		send_tick(mk_tick(32'd250000, F_LOWBAT, 4'd0));
		send_tick(mk_tick(32'd250001, F_LOWBAT, 4'd0));
		send_tick(mk_tick(32'd75000, F_BIND, 4'd0));
		send_tick(mk_tick(32'd175001, F_BIND, 4'd0));
		send_tick(mk_tick(32'd468751, F_FAILSAFE, 4'd0));
		// everything at once; gesture and a full blink count are latched underneath
		send_tick(mk_tick(32'hFFFF_FFFF,
			F_LOWBAT | F_BIND | F_FAILSAFE | F_GESTURE | F_LOAD, 4'd15));
	endtask

	// gesture lifetime, then the blink sequence on the shared mark
	task automatic test_gesture_blink();
		send_tick(mk_tick(32'd1000000, F_GESTURE, 4'd0));
		send_tick(mk_tick(32'd1050001, F_NONE, 4'd0));
		send_tick(mk_tick(32'd1500000, F_NONE, 4'd0));
		send_tick(mk_tick(32'd1500001, F_NONE, 4'd0));
		send_tick(mk_tick(32'd2000000, F_LOAD, 4'd2));
		send_tick(mk_tick(32'd2300000, F_NONE, 4'd0));
		send_tick(mk_tick(32'd2300001, F_NONE, 4'd0));
		send_tick(mk_tick(32'd2500001, F_NONE, 4'd0));
		send_tick(mk_tick(32'd2600000, F_NONE, 4'd0));
		// higher priority in the middle of a blink leaves the mark alone
		send_tick(mk_tick(32'd2700000, F_LOWBAT, 4'd0));
		send_tick(mk_tick(32'd2800000, F_LOAD, 4'd0));
	endtask

	// disabled driving, too many LEDs, partial fit, zero and maximum loop period
	task automatic test_register_corners();
		apply_settings(4'd15, 3'd0, 4'hF, 16'd250);
		send_tick(mk_tick(32'd3000000, F_GESTURE | F_LOAD, 4'd3));
		apply_settings(4'd15, 3'd7, 4'hF, 16'd250);
		send_tick(mk_tick(32'd3000001, F_NONE, 4'd0));
		apply_settings(4'd15, 3'd2, 4'h5, 16'd250);
		send_tick(mk_tick(32'd3050001, F_NONE, 4'd0));
		send_tick(mk_tick(32'd3600000, F_NONE, 4'd0));
		send_tick(mk_tick(32'd3600100, F_LOAD, 4'd0));
		apply_settings(4'd1, 3'd4, 4'h0, 16'd0);
		send_tick(mk_tick(32'd3600200, F_NONE, 4'd0));
		send_tick(mk_tick(32'd3800000, F_NONE, 4'd0));
		apply_settings(4'd14, 3'd4, 4'h9, 16'hFFFF);
		send_tick(mk_tick(32'd3800250, F_NONE, 4'd0));
		send_tick(mk_tick(32'd3900000, F_NONE, 4'd0));
		clock_us = 32'd4000000;
	endtask

	// ticks on an advancing clock; mostly quiet flags so gestures, blinks and
	// the dimmer run through whole sequences, with status flags breaking in
	task automatic send_random_ticks(input int n);
		int          sel;
		logic [31:0] step;
		logic [4:0]  flags;
		logic [3:0]  count;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 50)
				step = $urandom_range(0, 2 * int'(cfg_period) + 2);
			else if (sel < 85)
				step = $urandom_range(1000, 60000);
			else if (sel < 95)
				step = $urandom_range(0, 200000);
			else if (sel < 97)
				step = 32'd0;
			else
				step = $urandom;
			clock_us = clock_us + step;
			flags = F_NONE;
			if ($urandom_range(0, 99) < 6)
				flags = flags | F_LOWBAT;
			if ($urandom_range(0, 99) < 6)
				flags = flags | F_BIND;
			if ($urandom_range(0, 99) < 6)
				flags = flags | F_FAILSAFE;
			if ($urandom_range(0, 99) < 3)
				flags = flags | F_GESTURE;
			if ($urandom_range(0, 99) < 4)
				flags = flags | F_LOAD;
			// short blink runs most of the time
			count = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(1, 3))
				: 4'($urandom_range(0, 15));
			send_tick(mk_tick(clock_us, flags, count));
		end
	endtask

	// register settings from fixed extremes to random ones
	task automatic test_random_phases();
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: apply_settings(4'd15, 3'd4, 4'h0, 16'd250);
				1: apply_settings(4'd0, 3'd4, 4'hF, 16'd250);
				2: apply_settings(4'd7, 3'd4, 4'h0, 16'd250);
				3: apply_settings(4'd1, 3'd3, 4'h5, 16'd1);
				4: apply_settings(4'd14, 3'd7, 4'hA, 16'hFFFF);
				5: apply_settings(4'd8, 3'd1, 4'h3, 16'd0);
				6: apply_settings(4'd3, 3'd2, 4'hC, 16'd1000);
				default: apply_settings(4'($urandom_range(0, 15)), 3'($urandom_range(1, 7)),
					4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
			endcase
			// one phase runs with no idling on either side
			steady_flow = (ph == 2);
			send_random_ticks(PHASE_TICKS);
		end
		steady_flow = 1'b0;
	endtask

	// ---------------- sequence ----------------

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_flash_thresholds();
		test_gesture_blink();
		test_register_corners();
		test_random_phases();

		wait_idle();
		errors = errors + led_queue.size();
		$display("%0d ticks checked over %0d register writes, %0d results compared",
			ticks_sent, reg_writes, results_checked);
		$display("patterns: lowbatt %0d bind %0d failsafe %0d gesture %0d blink %0d steady %0d disabled %0d",
			pat_seen[0], pat_seen[1], pat_seen[2], pat_seen[3], pat_seen[4], pat_seen[5],
			pat_seen[6]);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
hdl/lsi_pkg.sv
hdl/led_status_indicator_top.sv
tb/sv/led_status_indicator_top_tb.sv
